>>> src/ttlc_pkg.sv
// Shared types, register codes and reset values for the thermal throttle level controller.
`default_nettype none
package ttlc_pkg;

    localparam int TEMP_W  = 16;
    localparam int FREQ_W  = 24;
    localparam int MS_W    = 16;
    localparam int TOTAL_W = 40;
    localparam int BAND_W  = 32;
    localparam int LVL_W   = 2;
    localparam int NUM_LVL = 3;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = 3;

    // throttle levels
    localparam logic [LVL_W-1:0] LVL_NONE = 2'd0;
    localparam logic [LVL_W-1:0] LVL_LOW  = 2'd1;
    localparam logic [LVL_W-1:0] LVL_MID  = 2'd2;
    localparam logic [LVL_W-1:0] LVL_MAX  = 2'd3;

    // register indexes (byte address / 4)
    localparam logic [IDX_W-1:0] REG_SHUTDOWN = 3'd0;
    localparam logic [IDX_W-1:0] REG_LOW_BAND = 3'd1;
    localparam logic [IDX_W-1:0] REG_MID_BAND = 3'd2;
    localparam logic [IDX_W-1:0] REG_MAX_BAND = 3'd3;
    localparam logic [IDX_W-1:0] REG_LOW_CAP  = 3'd4;
    localparam logic [IDX_W-1:0] REG_MID_CAP  = 3'd5;
    localparam logic [IDX_W-1:0] REG_MAX_CAP  = 3'd6;

    // register reset values
    localparam logic [TEMP_W-1:0] RST_SHUTDOWN = 16'd100;
    localparam logic [BAND_W-1:0] RST_LOW_BAND = 32'd3932215;
    localparam logic [BAND_W-1:0] RST_MID_BAND = 32'd4587585;
    localparam logic [BAND_W-1:0] RST_MAX_BAND = 32'd5242955;
    localparam logic [FREQ_W-1:0] RST_LOW_CAP  = 24'd1728000;
    localparam logic [FREQ_W-1:0] RST_MID_CAP  = 24'd1512000;
    localparam logic [FREQ_W-1:0] RST_MAX_CAP  = 24'd1188000;

    typedef logic [NUM_LVL-1:0][TOTAL_W-1:0] t_totals;

    typedef struct packed {
        logic [TEMP_W-1:0] temperature;
        logic              sensor_fault;
        logic [FREQ_W-1:0] present_limit;
        logic [MS_W-1:0]   elapsed_ms;
    } t_in_beat;

    typedef struct packed {
        logic [LVL_W-1:0]   level;
        logic               cap_valid;
        logic [FREQ_W-1:0]  freq_cap;
        logic               shutdown;
        logic [TOTAL_W-1:0] low_time_ms;
        logic [TOTAL_W-1:0] mid_time_ms;
        logic [TOTAL_W-1:0] max_time_ms;
    } t_out_beat;

    typedef struct packed {
        logic [TEMP_W-1:0] shutdown_level;
        logic [BAND_W-1:0] low_band;
        logic [BAND_W-1:0] mid_band;
        logic [BAND_W-1:0] max_band;
        logic [FREQ_W-1:0] low_cap;
        logic [FREQ_W-1:0] mid_cap;
        logic [FREQ_W-1:0] max_cap;
    } t_cfg;

    typedef struct packed {
        logic [LVL_W-1:0]  level;
        logic [FREQ_W-1:0] saved_limit;
        t_totals           totals;
    } t_state;

endpackage
`default_nettype wire

>>> src/thermal_throttle_level_controller_top.sv
// Top level of the thermal throttle level controller: pipeline, state and register port.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------------
//  in      | sink      | i_in_valid / o_in_stall | i_in_data  (t_in_beat)
//  out     | source    | o_out_valid / i_out_stall | o_out_data (t_out_beat)
//  cfg     | APB slave | psel/penable/pready     | paddr, pwdata, prdata
//
// One beat per cycle sustained while the output is not stalled. A sample is
// captured in the input register, and its decision is folded into the throttle
// state as it moves into the result register that drives o_out_valid.
// Synchronous active-low reset clears the valids, the level, saved limit and
// time totals, and loads the register defaults. A stall on the output holds
// both stages; o_in_stall rises only when the input register is full and
// cannot move forward.
`default_nettype none
module thermal_throttle_level_controller_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire ttlc_pkg::t_in_beat          i_in_data,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output ttlc_pkg::t_out_beat              o_out_data,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ttlc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [ttlc_pkg::DATA_W-1:0] pwdata,
    output logic      [ttlc_pkg::DATA_W-1:0] prdata,
    output logic                             pready
);
    import ttlc_pkg::*;

    t_cfg      cfg;
    t_state    r_state;
    t_state    n_state;
    t_out_beat n_result;

    logic      r_in_valid;
    t_in_beat  r_in;
    logic      r_out_valid;
    t_out_beat r_out;
    logic      advance;

    ttlc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ttlc_decide u_decide (
        .i_cfg    (cfg),
        .i_beat   (r_in),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // result register free or being drained this cycle
    assign advance     = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_in_valid && !advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_state <= n_state;
                end
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (advance && r_in_valid) begin
            r_out <= n_result;
        end
    end

endmodule
`default_nettype wire

>>> src/ttlc_regs.sv
// APB register file holding thresholds and frequency caps.
`default_nettype none
module ttlc_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ttlc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [ttlc_pkg::DATA_W-1:0] pwdata,
    output logic      [ttlc_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    output ttlc_pkg::t_cfg                   o_cfg
);
    import ttlc_pkg::*;

    t_cfg             r_cfg;
    logic [IDX_W-1:0] idx;
    logic             wr_en;

    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.shutdown_level <= RST_SHUTDOWN;
            r_cfg.low_band       <= RST_LOW_BAND;
            r_cfg.mid_band       <= RST_MID_BAND;
            r_cfg.max_band       <= RST_MAX_BAND;
            r_cfg.low_cap        <= RST_LOW_CAP;
            r_cfg.mid_cap        <= RST_MID_CAP;
            r_cfg.max_cap        <= RST_MAX_CAP;
        end else if (wr_en) begin
            case (idx)
                REG_SHUTDOWN: r_cfg.shutdown_level <= pwdata[TEMP_W-1:0];
                REG_LOW_BAND: r_cfg.low_band       <= pwdata[BAND_W-1:0];
                REG_MID_BAND: r_cfg.mid_band       <= pwdata[BAND_W-1:0];
                REG_MAX_BAND: r_cfg.max_band       <= pwdata[BAND_W-1:0];
                REG_LOW_CAP:  r_cfg.low_cap        <= pwdata[FREQ_W-1:0];
                REG_MID_CAP:  r_cfg.mid_cap        <= pwdata[FREQ_W-1:0];
                REG_MAX_CAP:  r_cfg.max_cap        <= pwdata[FREQ_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_SHUTDOWN: prdata = {{(DATA_W-TEMP_W){1'b0}}, r_cfg.shutdown_level};
            REG_LOW_BAND: prdata = r_cfg.low_band;
            REG_MID_BAND: prdata = r_cfg.mid_band;
            REG_MAX_BAND: prdata = r_cfg.max_band;
            REG_LOW_CAP:  prdata = {{(DATA_W-FREQ_W){1'b0}}, r_cfg.low_cap};
            REG_MID_CAP:  prdata = {{(DATA_W-FREQ_W){1'b0}}, r_cfg.mid_cap};
            REG_MAX_CAP:  prdata = {{(DATA_W-FREQ_W){1'b0}}, r_cfg.max_cap};
            default:      prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

>>> src/ttlc_decide.sv
// Per-sample decision: time accounting, shutdown, limit save and trip/clear rules.
`default_nettype none
module ttlc_decide (
    input  wire ttlc_pkg::t_cfg      i_cfg,
    input  wire ttlc_pkg::t_in_beat  i_beat,
    input  wire ttlc_pkg::t_state    i_state,
    output ttlc_pkg::t_state         o_state,
    output ttlc_pkg::t_out_beat      o_result
);
    import ttlc_pkg::*;

    logic [TEMP_W-1:0]  t;
    logic [TEMP_W-1:0]  low_trip, mid_trip, max_trip;
    logic [TEMP_W-1:0]  low_clr, mid_clr, max_clr;
    logic [TOTAL_W:0]   sums [NUM_LVL];
    t_totals            n_tot;
    logic [LVL_W-1:0]   lvl;
    logic [FREQ_W-1:0]  saved;
    logic               cap_valid;
    logic [FREQ_W-1:0]  cap;
    logic               shut;

    assign t        = i_beat.temperature;
    assign low_trip = i_cfg.low_band[BAND_W-1:TEMP_W];
    assign mid_trip = i_cfg.mid_band[BAND_W-1:TEMP_W];
    assign max_trip = i_cfg.max_band[BAND_W-1:TEMP_W];
    assign low_clr  = i_cfg.low_band[TEMP_W-1:0];
    assign mid_clr  = i_cfg.mid_band[TEMP_W-1:0];
    assign max_clr  = i_cfg.max_band[TEMP_W-1:0];

    // elapsed time goes to the level held during the interval; carry out saturates
    always_comb begin
        for (int i = 0; i < NUM_LVL; i++) begin
            sums[i] = {1'b0, i_state.totals[i]} + {{(TOTAL_W+1-MS_W){1'b0}}, i_beat.elapsed_ms};
            if (i_state.level == LVL_W'(i + 1)) begin
                n_tot[i] = sums[i][TOTAL_W] ? {TOTAL_W{1'b1}} : sums[i][TOTAL_W-1:0];
            end else begin
                n_tot[i] = i_state.totals[i];
            end
        end
    end

    always_comb begin
        lvl       = i_state.level;
        saved     = i_state.saved_limit;
        cap_valid = 1'b0;
        cap       = '0;
        shut      = 1'b0;
        if (!i_beat.sensor_fault) begin
            if (t >= i_cfg.shutdown_level) begin
                shut = 1'b1;
                lvl  = LVL_MAX;
            end
            if (lvl == LVL_NONE) begin
                saved = i_beat.present_limit;
            end
            if (t >= low_trip && t < mid_trip && lvl < LVL_LOW) begin
                cap_valid = 1'b1;
                cap       = i_cfg.low_cap;
                lvl       = LVL_LOW;
            end else if (t < low_clr && lvl > LVL_NONE) begin
                cap_valid = 1'b1;
                cap       = (saved != '0) ? saved : i_beat.present_limit;
                lvl       = LVL_NONE;
            end else if (t >= mid_trip && t < max_trip && lvl < LVL_MID) begin
                cap_valid = 1'b1;
                cap       = i_cfg.mid_cap;
                lvl       = LVL_MID;
            end else if (t < mid_clr && lvl > LVL_LOW) begin
                cap_valid = 1'b1;
                cap       = i_cfg.low_cap;
                lvl       = LVL_LOW;
            end else if (t >= max_trip) begin
                cap_valid = 1'b1;
                cap       = i_cfg.max_cap;
                lvl       = LVL_MAX;
            end else if (t < max_clr && lvl > LVL_MID) begin
                cap_valid = 1'b1;
                cap       = i_cfg.mid_cap;
                lvl       = LVL_MID;
            end
        end
    end

    assign o_state.level       = lvl;
    assign o_state.saved_limit = saved;
    assign o_state.totals      = n_tot;

    assign o_result.level       = lvl;
    assign o_result.cap_valid   = cap_valid;
    assign o_result.freq_cap    = cap;
    assign o_result.shutdown    = shut;
    assign o_result.low_time_ms = n_tot[0];
    assign o_result.mid_time_ms = n_tot[1];
    assign o_result.max_time_ms = n_tot[2];

endmodule
`default_nettype wire
